### rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console write engine package
// Screen geometry, command codes and request/response types shared by the
// console write engine.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS     = 40;
    localparam int ROWS        = 25;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int SHIFT_CELLS = CELLS - COLUMNS;
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int CNT_W       = $clog2(CELLS + 1);

    // Cursor register widths, fixed by the response fields.
    localparam int COL_W = 8;
    localparam int ROW_W = 7;

    // Color byte after reset: white foreground on black background.
    localparam logic [7:0] COLOR_RESET = 8'h0f;

    // Command codes.
    localparam logic [3:0] OP_PRINT   = 4'd0;
    localparam logic [3:0] OP_NEWLINE = 4'd1;
    localparam logic [3:0] OP_SCROLL  = 4'd2;
    localparam logic [3:0] OP_CLEAR   = 4'd3;
    localparam logic [3:0] OP_COMMIT  = 4'd4;
    localparam logic [3:0] OP_SET_FG  = 4'd5;
    localparam logic [3:0] OP_SET_BG  = 4'd6;
    localparam logic [3:0] OP_SET_X   = 4'd7;
    localparam logic [3:0] OP_SET_Y   = 4'd8;
    localparam logic [3:0] OP_READ    = 4'd9;

    // Command request.
    typedef struct packed {
        logic [3:0] operation;
        logic [7:0] char_code;
        logic [3:0] color_value;
        logic [6:0] column_in;
        logic [5:0] row_in;
    } t_cmd;

    // Command response.
    typedef struct packed {
        logic [7:0] cursor_col;
        logic [6:0] cursor_row;
        logic [7:0] cell_char;
        logic [7:0] cell_color;
    } t_rsp;

    // One screen cell as stored in memory.
    typedef struct packed {
        logic [7:0] color;
        logic [7:0] chr;
    } t_cell;

endpackage

### rtl/text_console_write_engine_core.sv
// ----------------------------------------------------------------------------
// Text console write engine
// Double-buffered text console: a work screen edited by commands and a ready
// screen that a commit copies it to and a read command samples.
// ----------------------------------------------------------------------------

// Print, newline, color and cursor commands respond from the accepting state when
// the response slot is free; a read first samples the ready screen. Scroll, clear
// and commit, and a print or newline that scrolls the screen, walk the work screen
// memory one cell per cycle through its single write port. After reset the engine
// runs a clearing pass over both screens and takes no request until it is done.
// A response waits in an output register, and the next request is taken while it
// waits.
module text_console_write_engine_core
    import tcw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    output logic o_cmd_ready,
    input  t_cmd i_cmd,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    // Controller states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    // Kinds of memory sweep.
    localparam logic [1:0] SW_INIT   = 2'd0;
    localparam logic [1:0] SW_SCROLL = 2'd1;
    localparam logic [1:0] SW_CLEAR  = 2'd2;
    localparam logic [1:0] SW_COMMIT = 2'd3;

    // Screen memories.
    t_cell work_mem  [CELLS];
    t_cell ready_mem [CELLS];

    logic [1:0]       r_state, n_state;
    logic [1:0]       r_sweep_kind, n_sweep_kind;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [COL_W-1:0] r_cur_col, n_cur_col;
    logic [ROW_W-1:0] r_cur_row, n_cur_row;
    logic [7:0]       r_color, n_color;
    logic             r_pend_print, n_pend_print;
    logic [ADDR_W-1:0] r_pend_addr, n_pend_addr;
    t_cell            r_pend_cell, n_pend_cell;
    logic             r_is_read, n_is_read;
    logic             r_rd_hit, n_rd_hit;
    logic             r_rsp_valid, n_rsp_valid;
    t_rsp             r_rsp, n_rsp;

    t_cell            r_work_rdata;
    t_cell            r_ready_rdata;

    // Memory port controls.
    logic              w_work_we;
    logic [ADDR_W-1:0] w_work_waddr;
    t_cell             w_work_wdata;
    logic              w_work_re;
    logic [ADDR_W-1:0] w_work_raddr;
    logic              w_ready_we;
    t_cell             w_ready_wdata;
    logic              w_ready_re;
    logic [ADDR_W-1:0] w_ready_raddr;

    // Print cursor arithmetic.
    logic              w_accept;
    logic              w_slot_free;
    logic              w_wrap;
    logic [COL_W-1:0]  w_col1;
    logic [ROW_W-1:0]  w_row1;
    logic              w_pscroll;
    logic [ROW_W-1:0]  w_row2;
    logic [ADDR_W-1:0] w_print_addr;
    logic              w_nscroll;
    logic              w_rd_in_range;
    logic [CNT_W-1:0]  w_cnt_m1;
    logic [ADDR_W-1:0] w_sweep_waddr;
    logic [CNT_W:0]    w_scroll_src;

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    assign w_accept    = i_cmd_valid && o_cmd_ready;
    assign w_slot_free = !r_rsp_valid || i_rsp_ready;

    // Cursor position used by a print: wrap at the line end, then scroll
    // lazily when the cursor has passed the last row.
    assign w_wrap    = (r_cur_col >= COL_W'(COLUMNS));
    assign w_col1    = w_wrap ? '0 : r_cur_col;
    assign w_row1    = w_wrap ? (r_cur_row + ROW_W'(1)) : r_cur_row;
    assign w_pscroll = (w_row1 >= ROW_W'(ROWS));
    assign w_row2    = w_pscroll ? ROW_W'(ROWS - 1) : w_row1;
    assign w_print_addr = ADDR_W'(int'(w_row2) * COLUMNS + int'(w_col1));
    assign w_nscroll = (r_cur_row >= ROW_W'(ROWS));

    assign w_rd_in_range = (int'(i_cmd.column_in) < COLUMNS) && (int'(i_cmd.row_in) < ROWS);

    // Sweep addressing: the write address trails the sweep count by one cell.
    assign w_cnt_m1      = r_cnt - CNT_W'(1);
    assign w_sweep_waddr = w_cnt_m1[ADDR_W-1:0];
    assign w_scroll_src  = {1'b0, r_cnt} + (CNT_W + 1)'(COLUMNS);

    // Next-state logic for the controller, cursor and memory ports.
    always_comb begin
        n_state      = r_state;
        n_sweep_kind = r_sweep_kind;
        n_cnt        = r_cnt;
        n_cur_col    = r_cur_col;
        n_cur_row    = r_cur_row;
        n_color      = r_color;
        n_pend_print = r_pend_print;
        n_pend_addr  = r_pend_addr;
        n_pend_cell  = r_pend_cell;
        n_is_read    = r_is_read;
        n_rd_hit     = r_rd_hit;
        n_rsp_valid  = r_rsp_valid && !i_rsp_ready;
        n_rsp        = r_rsp;

        w_work_we     = 1'b0;
        w_work_waddr  = w_sweep_waddr;
        w_work_wdata  = '0;
        w_work_re     = 1'b0;
        w_work_raddr  = r_cnt[ADDR_W-1:0];
        w_ready_we    = 1'b0;
        w_ready_wdata = '0;
        w_ready_re    = 1'b0;
        w_ready_raddr = ADDR_W'(int'(i_cmd.row_in) * COLUMNS + int'(i_cmd.column_in));

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_is_read    = 1'b0;
                    n_pend_print = 1'b0;
                    n_cnt        = '0;
                    n_state      = ST_DONE;
                    unique case (i_cmd.operation)
                        OP_PRINT: begin
                            n_cur_col = w_col1 + COL_W'(1);
                            n_cur_row = w_row2;
                            if (w_pscroll) begin
                                // The character lands in the cleared bottom row.
                                n_pend_print = 1'b1;
                                n_pend_addr  = w_print_addr;
                                n_pend_cell  = '{color: r_color, chr: i_cmd.char_code};
                                n_sweep_kind = SW_SCROLL;
                                n_state      = ST_SWEEP;
                            end else begin
                                w_work_we    = 1'b1;
                                w_work_waddr = w_print_addr;
                                w_work_wdata = '{color: r_color, chr: i_cmd.char_code};
                            end
                        end
                        OP_NEWLINE: begin
                            n_cur_col = '0;
                            if (w_nscroll) begin
                                n_cur_row    = ROW_W'(ROWS);
                                n_sweep_kind = SW_SCROLL;
                                n_state      = ST_SWEEP;
                            end else begin
                                n_cur_row = r_cur_row + ROW_W'(1);
                            end
                        end
                        OP_SCROLL: begin
                            if (r_cur_row != '0) begin
                                n_cur_row = r_cur_row - ROW_W'(1);
                            end
                            n_sweep_kind = SW_SCROLL;
                            n_state      = ST_SWEEP;
                        end
                        OP_CLEAR: begin
                            n_sweep_kind = SW_CLEAR;
                            n_state      = ST_SWEEP;
                        end
                        OP_COMMIT: begin
                            n_sweep_kind = SW_COMMIT;
                            n_state      = ST_SWEEP;
                        end
                        OP_SET_FG: begin
                            n_color = {r_color[7:4], i_cmd.color_value};
                        end
                        OP_SET_BG: begin
                            n_color = {i_cmd.color_value, r_color[3:0]};
                        end
                        OP_SET_X: begin
                            if (int'(i_cmd.column_in) < COLUMNS) begin
                                n_cur_col = COL_W'(i_cmd.column_in);
                            end
                        end
                        OP_SET_Y: begin
                            if (int'(i_cmd.row_in) < ROWS) begin
                                n_cur_row = ROW_W'(i_cmd.row_in);
                            end
                        end
                        OP_READ: begin
                            n_is_read  = 1'b1;
                            n_rd_hit   = w_rd_in_range;
                            w_ready_re = w_rd_in_range;
                        end
                        default: begin
                        end
                    endcase

                    // Commands that need no sweep or read respond at once when the slot is free.
                    if (n_state == ST_DONE && !n_is_read && w_slot_free) begin
                        n_rsp_valid = 1'b1;
                        n_rsp       = '{cursor_col: n_cur_col, cursor_row: n_cur_row,
                                        cell_char: '0, cell_color: '0};
                        n_state     = ST_IDLE;
                    end
                end
            end

            ST_SWEEP: begin
                // Write port: trails the sweep count by one cell.
                unique case (r_sweep_kind)
                    SW_INIT: begin
                        w_work_we  = (r_cnt != '0);
                        w_ready_we = (r_cnt != '0);
                    end
                    SW_CLEAR: begin
                        w_work_we = (r_cnt != '0);
                    end
                    SW_SCROLL: begin
                        w_work_we    = (r_cnt != '0);
                        w_work_re    = (r_cnt < CNT_W'(SHIFT_CELLS));
                        w_work_raddr = w_scroll_src[ADDR_W-1:0];
                        if (r_cnt <= CNT_W'(SHIFT_CELLS)) begin
                            w_work_wdata = r_work_rdata;
                        end else if (r_pend_print && w_sweep_waddr == r_pend_addr) begin
                            w_work_wdata = r_pend_cell;
                        end
                    end
                    SW_COMMIT: begin
                        w_work_re     = (r_cnt < CNT_W'(CELLS));
                        w_ready_we    = (r_cnt != '0);
                        w_ready_wdata = r_work_rdata;
                    end
                    default: begin
                    end
                endcase

                if (r_cnt == CNT_W'(CELLS)) begin
                    n_state = (r_sweep_kind == SW_INIT) ? ST_IDLE : ST_DONE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end

            ST_DONE: begin
                if (w_slot_free) begin
                    n_rsp_valid = 1'b1;
                    n_rsp       = '{cursor_col: r_cur_col, cursor_row: r_cur_row,
                                    cell_char:  (r_is_read && r_rd_hit) ? r_ready_rdata.chr : '0,
                                    cell_color: (r_is_read && r_rd_hit) ? r_ready_rdata.color : '0};
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and cursor registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep_kind <= SW_INIT;
            r_cnt        <= '0;
            r_cur_col    <= '0;
            r_cur_row    <= '0;
            r_color      <= COLOR_RESET;
            r_pend_print <= 1'b0;
            r_is_read    <= 1'b0;
            r_rd_hit     <= 1'b0;
            r_rsp_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep_kind <= n_sweep_kind;
            r_cnt        <= n_cnt;
            r_cur_col    <= n_cur_col;
            r_cur_row    <= n_cur_row;
            r_color      <= n_color;
            r_pend_print <= n_pend_print;
            r_is_read    <= n_is_read;
            r_rd_hit     <= n_rd_hit;
            r_rsp_valid  <= n_rsp_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pend_addr <= n_pend_addr;
        r_pend_cell <= n_pend_cell;
        r_rsp       <= n_rsp;
    end

    // Work screen memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_work_we) begin
            work_mem[w_work_waddr] <= w_work_wdata;
        end
        if (w_work_re) begin
            r_work_rdata <= work_mem[w_work_raddr];
        end
    end

    // Ready screen memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_ready_we) begin
            ready_mem[w_sweep_waddr] <= w_ready_wdata;
        end
        if (w_ready_re) begin
            r_ready_rdata <= ready_mem[w_ready_raddr];
        end
    end

`ifndef NO_ASSERTIONS
    // The cursor row never goes past one row beyond the screen.
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_row <= ROW_W'(ROWS))
        else $error("cursor row beyond screen");

    // The sweep counter stays within the memory plus the trailing write.
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> (r_cnt <= CNT_W'(CELLS)))
        else $error("sweep counter overrun");

    // A direct print always writes inside the screen.
    a_print_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_cmd.operation == OP_PRINT && !w_pscroll)
            |-> (int'(w_print_addr) < CELLS))
        else $error("print address outside screen");

    // After a print the cursor has advanced past column zero.
    a_print_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_cmd.operation == OP_PRINT) |=> (r_cur_col != '0))
        else $error("print did not advance cursor");
`endif

endmodule

### bench/text_console_write_engine_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console write engine testbench
// Sends a directed set of console requests and then a long random stream
// through the command channel, with random gaps on both channels and long
// response hold-offs. A behavioral model of the work and ready screens
// predicts every response, and each response is compared field by field.
// ----------------------------------------------------------------------------
module text_console_write_engine_core_tb;
    import tcw_pkg::*;

    // Run control.
    localparam int RANDOM_ITEMS = 1850;
    localparam int LIMIT_CYCLES = 8_000_000;
    localparam int DRAIN_CYCLES = CELLS + 10;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_FIRST   = 500;
    localparam int HOLD_SECOND  = 1500;
    localparam int MAX_REPORTS  = 10;

    // Gap rates in percent for the first and second idling phases.
    localparam int IDLE_LOW  = 33;
    localparam int IDLE_HIGH = 46;

    // Codes the engine does not decode.
    localparam logic [3:0] OP_SPARE_LO = 4'd10;
    localparam logic [3:0] OP_SPARE_HI = 4'd15;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_cmd_valid = 1'b0;
    logic i_rsp_ready = 1'b0;
    t_cmd i_cmd       = '0;
    logic o_cmd_ready;
    logic o_rsp_valid;
    t_rsp o_rsp;

    text_console_write_engine_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd_valid),
        .o_cmd_ready (o_cmd_ready),
        .i_cmd       (i_cmd),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always #6 i_clk = ~i_clk;

    // Requests waiting to be sent and responses still owed by the engine.
    t_cmd req_backlog[$];
    t_rsp replies_due[$];

    int unsigned total_items   = 0;
    int unsigned cmd_taken_cnt = 0;
    int unsigned reply_cnt     = 0;
    int unsigned fault_cnt     = 0;
    int unsigned cycle_cnt     = 0;
    int unsigned hold_left     = 0;
    int unsigned hold_idx      = 0;
    bit          cmd_accepted  = 1'b0;

    // Screen model: work and ready screens, cursor and current color.
    logic [7:0]  work_chr  [CELLS];
    logic [7:0]  work_clr  [CELLS];
    logic [7:0]  shown_chr [CELLS];
    logic [7:0]  shown_clr [CELLS];
    int unsigned cur_x;
    int unsigned cur_y;
    logic [7:0]  pen;
    int unsigned shifts_done = 0;
    int unsigned reads_hit   = 0;

    // Move every work row up by one, blank the bottom row and raise the cursor unless it is on the top row.
    function automatic void shift_rows_up();
        for (int i = 0; i < SHIFT_CELLS; i++) begin
            work_chr[i] = work_chr[i + COLUMNS];
            work_clr[i] = work_clr[i + COLUMNS];
        end
        for (int i = SHIFT_CELLS; i < CELLS; i++) begin
            work_chr[i] = '0;
            work_clr[i] = '0;
        end
        if (cur_y > 0) begin
            cur_y--;
        end
        shifts_done++;
    endfunction

    // Apply one request to the screen model and return the response it owes.
    function automatic t_rsp console_apply(input t_cmd c);
        t_rsp r;
        int   idx;
        r = '0;
        case (c.operation)
            OP_PRINT: begin
                if (cur_x >= COLUMNS) begin
                    cur_x = 0;
                    cur_y++;
                end
                if (cur_y >= ROWS) begin
                    shift_rows_up();
                    cur_y = ROWS - 1;
                end
                idx = cur_y * COLUMNS + cur_x;
                work_chr[idx] = c.char_code;
                work_clr[idx] = pen;
                cur_x++;
            end
            OP_NEWLINE: begin
                cur_x = 0;
                if (cur_y >= ROWS) begin
                    shift_rows_up();
                    cur_y = ROWS - 1;
                end
                cur_y++;
            end
            OP_SCROLL: begin
                shift_rows_up();
            end
            OP_CLEAR: begin
                for (int i = 0; i < CELLS; i++) begin
                    work_chr[i] = '0;
                    work_clr[i] = '0;
                end
            end
            OP_COMMIT: begin
                shown_chr = work_chr;
                shown_clr = work_clr;
            end
            OP_SET_FG: begin
                pen = {pen[7:4], c.color_value};
            end
            OP_SET_BG: begin
                pen = {c.color_value, pen[3:0]};
            end
            OP_SET_X: begin
                if (c.column_in < COLUMNS) begin
                    cur_x = c.column_in;
                end
            end
            OP_SET_Y: begin
                if (c.row_in < ROWS) begin
                    cur_y = c.row_in;
                end
            end
            OP_READ: begin
                if (c.column_in < COLUMNS && c.row_in < ROWS) begin
                    idx = c.row_in * COLUMNS + c.column_in;
                    r.cell_char  = shown_chr[idx];
                    r.cell_color = shown_clr[idx];
                    reads_hit++;
                end
            end
            default: begin
            end
        endcase
        r.cursor_col = 8'(cur_x);
        r.cursor_row = 7'(cur_y);
        return r;
    endfunction

    function automatic void queue_req(input logic [3:0] op, input logic [7:0] ch,
                                      input logic [3:0] cv, input logic [6:0] x,
                                      input logic [5:0] y);
        t_cmd c;
        c.operation   = op;
        c.char_code   = ch;
        c.color_value = cv;
        c.column_in   = x;
        c.row_in      = y;
        req_backlog.push_back(c);
    endfunction

    // The run goes through three thirds: sender gaps low, then high, then none.
    function automatic int idle_phase();
        if (cmd_taken_cnt * 3 < total_items) begin
            return 0;
        end else if (cmd_taken_cnt * 3 < 2 * total_items) begin
            return 1;
        end
        return 2;
    endfunction

    // Request driver: a new request is offered only once the last one is taken.
    always @(negedge i_clk) begin
        int pct;
        pct = (idle_phase() == 0) ? IDLE_LOW : (idle_phase() == 1) ? IDLE_HIGH : 0;
        if (!i_rst_n) begin
            i_cmd_valid <= 1'b0;
        end else if (!i_cmd_valid || cmd_accepted) begin
            cmd_accepted = 1'b0;
            if (req_backlog.size() > 0 && $urandom_range(99) >= pct) begin
                i_cmd       <= req_backlog.pop_front();
                i_cmd_valid <= 1'b1;
            end else begin
                i_cmd_valid <= 1'b0;
            end
        end
    end

    // Response ready: random gaps, and none at all during a hold-off.
    always @(negedge i_clk) begin
        int pct;
        pct = (idle_phase() == 0) ? IDLE_HIGH : (idle_phase() == 1) ? IDLE_LOW : 0;
        if (!i_rst_n || hold_left > 0) begin
            i_rsp_ready <= 1'b0;
        end else begin
            i_rsp_ready <= ($urandom_range(99) >= pct);
        end
    end

    // Long hold-offs on the response side let the engine fill up and stall.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
        end else if ((hold_idx == 0 && cmd_taken_cnt >= HOLD_FIRST) ||
                     (hold_idx == 1 && cmd_taken_cnt >= HOLD_SECOND)) begin
            hold_left = HOLD_CYCLES;
            hold_idx++;
        end
    end

    // Monitor: predict on every accepted request, check every accepted response.
    always @(posedge i_clk) begin : watch
        t_rsp want;
        bit   bad;
        if (i_rst_n) begin
            if (i_cmd_valid && o_cmd_ready) begin
                replies_due.push_back(console_apply(i_cmd));
                cmd_taken_cnt++;
                cmd_accepted = 1'b1;
            end
            if (o_rsp_valid && i_rsp_ready) begin
                reply_cnt++;
                if (replies_due.size() == 0) begin
                    fault_cnt++;
                    if (fault_cnt <= MAX_REPORTS) begin
                        $display("reply %0d arrived with no request outstanding: %h",
                                 reply_cnt, o_rsp);
                    end
                end else begin
                    want = replies_due.pop_front();
                    bad  = (o_rsp.cursor_col !== want.cursor_col) ||
                           (o_rsp.cursor_row !== want.cursor_row) ||
                           (o_rsp.cell_char  !== want.cell_char)  ||
                           (o_rsp.cell_color !== want.cell_color);
                    if (bad) begin
                        fault_cnt++;
                        if (fault_cnt <= MAX_REPORTS) begin
                            $display({"reply %0d: expected col %0d row %0d chr %h clr %h,",
                                      " got col %0d row %0d chr %h clr %h"},
                                     reply_cnt, want.cursor_col, want.cursor_row,
                                     want.cell_char, want.cell_color, o_rsp.cursor_col,
                                     o_rsp.cursor_row, o_rsp.cell_char, o_rsp.cell_color);
                        end
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin : stim
        bit [31:0]  rv;
        int         w;
        logic [3:0] op;
        logic [6:0] x;
        logic [5:0] y;

        // Model state after reset.
        for (int i = 0; i < CELLS; i++) begin
            work_chr[i]  = '0;
            work_clr[i]  = '0;
            shown_chr[i] = '0;
            shown_clr[i] = '0;
        end
        cur_x = 0;
        cur_y = 0;
        pen   = COLOR_RESET;

        // Directed part: field extremes, wrap, lazy scroll, ignored sets.
        queue_req(OP_READ,    8'h00, 4'h0, 7'd0, 6'd0);
        queue_req(OP_SET_FG,  8'h00, 4'h0, 7'd0, 6'd0);
        queue_req(OP_SET_BG,  8'h00, 4'hf, 7'd0, 6'd0);
        queue_req(OP_PRINT,   8'hff, 4'h0, 7'd0, 6'd0);
        queue_req(OP_SET_X,   8'h00, 4'h0, 7'(COLUMNS - 1), 6'd0);
        queue_req(OP_PRINT,   8'h00, 4'h0, 7'd0, 6'd0);
        queue_req(OP_PRINT,   8'h41, 4'h0, 7'd0, 6'd0);
        queue_req(OP_SET_X,   8'h00, 4'h0, 7'd127, 6'd0);
        queue_req(OP_SET_Y,   8'h00, 4'h0, 7'd0, 6'd63);
        queue_req(OP_SET_X,   8'h00, 4'h0, 7'(COLUMNS), 6'd0);
        queue_req(OP_SET_Y,   8'h00, 4'h0, 7'd0, 6'(ROWS));
        queue_req(OP_COMMIT,  8'h00, 4'h0, 7'd0, 6'd0);
        queue_req(OP_READ,    8'h00, 4'h0, 7'd0, 6'd0);
        queue_req(OP_READ,    8'h00, 4'h0, 7'(COLUMNS - 1), 6'd0);
        queue_req(OP_READ,    8'h00, 4'h0, 7'd127, 6'd63);
        queue_req(OP_SET_Y,   8'h00, 4'h0, 7'd0, 6'(ROWS - 1));
        queue_req(OP_SET_X,   8'h00, 4'h0, 7'(COLUMNS - 1), 6'd0);
        queue_req(OP_PRINT,   8'h5a, 4'h0, 7'd0, 6'd0);
        queue_req(OP_PRINT,   8'h59, 4'h0, 7'd0, 6'd0);
        queue_req(OP_NEWLINE, 8'h00, 4'h0, 7'd0, 6'd0);
        queue_req(OP_NEWLINE, 8'h00, 4'h0, 7'd0, 6'd0);
        queue_req(OP_SCROLL,  8'h00, 4'h0, 7'd0, 6'd0);
        queue_req(OP_SPARE_HI, 8'h00, 4'h0, 7'd0, 6'd0);
        queue_req(OP_CLEAR,   8'h00, 4'h0, 7'd0, 6'd0);

        // Random part: mostly text and cursor moves, few full-screen passes.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            rv = $urandom;
            w  = $urandom_range(99);
            x  = rv[22:16];
            y  = rv[28:23];
            if (w < 40) begin
                op = OP_PRINT;
            end else if (w < 48) begin
                op = OP_NEWLINE;
            end else if (w < 49) begin
                op = OP_SCROLL;
            end else if (w < 50) begin
                op = OP_CLEAR;
            end else if (w < 52) begin
                op = OP_COMMIT;
            end else if (w < 57) begin
                op = OP_SET_FG;
            end else if (w < 62) begin
                op = OP_SET_BG;
            end else if (w < 70) begin
                op = OP_SET_X;
                w  = $urandom_range(99);
                if (w < 20) begin
                    x = 7'(COLUMNS - 1);
                end else if (w < 80) begin
                    x = 7'($urandom_range(COLUMNS - 1));
                end
            end else if (w < 78) begin
                op = OP_SET_Y;
                w  = $urandom_range(99);
                if (w < 25) begin
                    y = 6'(ROWS - 1);
                end else if (w < 80) begin
                    y = 6'($urandom_range(ROWS - 1));
                end
            end else if (w < 98) begin
                op = OP_READ;
                if ($urandom_range(99) < 80) begin
                    x = 7'($urandom_range(COLUMNS - 1));
                    y = 6'($urandom_range(ROWS - 1));
                end
            end else begin
                op = 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
            end
            queue_req(op, rv[7:0], rv[11:8], x, y);
        end
        total_items = req_backlog.size();

        // Hold synchronous reset, then release it on a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to be taken and answered, then let it settle.
        while (cmd_taken_cnt < total_items || replies_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d requests and checked %0d responses, %0d of them in-screen reads.",
                 total_items, reply_cnt, reads_hit);
        $display("The model shifted the work screen %0d times; %0d mismatches were seen.",
                 shifts_done, fault_cnt);
        if (fault_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/tcw_pkg.sv
rtl/text_console_write_engine_core.sv
bench/text_console_write_engine_core_tb.sv
